/* hw/rtl/pws_pkg.sv */
`default_nettype none

package pws_pkg;

   // default sizes of the smoother
   localparam int DEF_HISTORY_DEPTH = 5;
   localparam int DEF_COORD_BITS    = 12;

   // controller states
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_ACCUM,
      ST_PREP,
      ST_DIVIDE,
      ST_DONE
   } pws_state_type;

   // commands from the controller to the datapath
   typedef struct packed {
      logic load;
      logic accum;
      logic div_start;
      logic div_step;
      logic result_load;
   } pws_cmd_type;

   // status from the datapath to the controller
   typedef struct packed {
      logic accum_last;
      logic div_last;
   } pws_status_type;

endpackage

`default_nettype wire

/* hw/rtl/pws_div.sv */
`default_nettype none

module pws_div #(
   parameter int QUO_BITS = 12,
   parameter int DIV_BITS = 4
) (
   input  wire logic                         clock,
   input  wire logic                         start,
   input  wire logic                         step,
   input  wire logic [QUO_BITS+DIV_BITS-1:0] dividend,
   input  wire logic [DIV_BITS-1:0]          divisor,
   output logic      [QUO_BITS-1:0]          quotient
);

   // partial remainder stays below the divisor between steps
   logic [DIV_BITS-1:0] rem_ff;
   logic [DIV_BITS-1:0] rem_in;
   logic [QUO_BITS-1:0] quo_ff;
   logic [DIV_BITS:0]   trial;
   logic [DIV_BITS:0]   diff;
   logic                fits;

   // one restoring step: bring down the next dividend bit and try the subtract
   always_comb begin
      trial = {rem_ff, quo_ff[QUO_BITS-1]};
      fits  = (trial >= {1'b0, divisor});
      diff  = trial - {1'b0, divisor};
      if (fits) begin
         rem_in = diff[DIV_BITS-1:0];
      end else begin
         rem_in = trial[DIV_BITS-1:0];
      end
   end

   // remainder and quotient shift register, low dividend bits shift out as quotient bits enter
   always_ff @(posedge clock) begin
      if (start) begin
         rem_ff <= dividend[QUO_BITS+DIV_BITS-1:QUO_BITS];
         quo_ff <= dividend[QUO_BITS-1:0];
      end else if (step) begin
         rem_ff <= rem_in;
         quo_ff <= {quo_ff[QUO_BITS-2:0], fits};
      end
   end

   assign quotient = quo_ff;

endmodule

`default_nettype wire

/* hw/rtl/pws_datapath.sv */
`default_nettype none

module pws_datapath #(
   parameter int HISTORY_DEPTH = 5,
   parameter int COORD_BITS    = 12
) (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire pws_pkg::pws_cmd_type    cmd,
   output pws_pkg::pws_status_type      status,
   input  wire logic [COORD_BITS-1:0]   point_x,
   input  wire logic [COORD_BITS-1:0]   point_y,
   output logic      [COORD_BITS-1:0]   smooth_x,
   output logic      [COORD_BITS-1:0]   smooth_y
);

   import pws_pkg::*;

   localparam int CNT_W = $clog2(HISTORY_DEPTH + 1);
   localparam int IDX_W = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
   localparam int TOT_W = $clog2(HISTORY_DEPTH * (HISTORY_DEPTH + 1) / 2 + 1);
   localparam int SUM_W = COORD_BITS + TOT_W;
   localparam int PRD_W = COORD_BITS + CNT_W;
   localparam int BIT_W = $clog2(COORD_BITS);

   logic [COORD_BITS-1:0] window_x_ff [HISTORY_DEPTH];
   logic [COORD_BITS-1:0] window_y_ff [HISTORY_DEPTH];
   logic [CNT_W-1:0]      fill_ff;
   logic [IDX_W-1:0]      idx_ff;
   logic [SUM_W-1:0]      sum_x_ff;
   logic [SUM_W-1:0]      sum_y_ff;
   logic [TOT_W-1:0]      total_ff;
   logic [BIT_W-1:0]      bit_ff;
   logic [COORD_BITS-1:0] smooth_x_ff;
   logic [COORD_BITS-1:0] smooth_y_ff;

   logic                  window_full;
   logic [CNT_W-1:0]      weight;
   logic [COORD_BITS-1:0] entry_x;
   logic [COORD_BITS-1:0] entry_y;
   logic [PRD_W-1:0]      prod_x;
   logic [PRD_W-1:0]      prod_y;
   logic [COORD_BITS-1:0] quo_x;
   logic [COORD_BITS-1:0] quo_y;

   // current tap, its weight and the weighted terms
   always_comb begin
      window_full = (fill_ff == CNT_W'(HISTORY_DEPTH));
      weight      = CNT_W'(idx_ff) + CNT_W'(1);
      entry_x     = window_x_ff[idx_ff];
      entry_y     = window_y_ff[idx_ff];
      prod_x      = PRD_W'(entry_x) * PRD_W'(weight);
      prod_y      = PRD_W'(entry_y) * PRD_W'(weight);
   end

   // history window: append while filling, shift out the oldest once full
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         if (window_full) begin
            for (int i = 0; i < HISTORY_DEPTH - 1; i++) begin
               window_x_ff[i] <= window_x_ff[i+1];
               window_y_ff[i] <= window_y_ff[i+1];
            end
            window_x_ff[HISTORY_DEPTH-1] <= point_x;
            window_y_ff[HISTORY_DEPTH-1] <= point_y;
         end else begin
            window_x_ff[fill_ff[IDX_W-1:0]] <= point_x;
            window_y_ff[fill_ff[IDX_W-1:0]] <= point_y;
         end
      end
   end

   // fill count, tap index and bit counter
   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff <= '0;
         idx_ff  <= '0;
         bit_ff  <= '0;
      end else begin
         if (cmd.load) begin
            idx_ff <= '0;
            if (!window_full) begin
               fill_ff <= fill_ff + CNT_W'(1);
            end
         end else if (cmd.accum) begin
            idx_ff <= idx_ff + IDX_W'(1);
         end
         if (cmd.div_start) begin
            bit_ff <= '0;
         end else if (cmd.div_step) begin
            bit_ff <= bit_ff + BIT_W'(1);
         end
      end
   end

   // weighted sums and total weight, one tap a cycle
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         sum_x_ff <= '0;
         sum_y_ff <= '0;
         total_ff <= '0;
      end else if (cmd.accum) begin
         sum_x_ff <= sum_x_ff + SUM_W'(prod_x);
         sum_y_ff <= sum_y_ff + SUM_W'(prod_y);
         total_ff <= total_ff + TOT_W'(weight);
      end
   end

   // one divider per coordinate, both stepped together
   pws_div #(
      .QUO_BITS (COORD_BITS),
      .DIV_BITS (TOT_W)
   ) u_div_x (
      .clock    (clock),
      .start    (cmd.div_start),
      .step     (cmd.div_step),
      .dividend (sum_x_ff),
      .divisor  (total_ff),
      .quotient (quo_x)
   );

   pws_div #(
      .QUO_BITS (COORD_BITS),
      .DIV_BITS (TOT_W)
   ) u_div_y (
      .clock    (clock),
      .start    (cmd.div_start),
      .step     (cmd.div_step),
      .dividend (sum_y_ff),
      .divisor  (total_ff),
      .quotient (quo_y)
   );

   // output register
   always_ff @(posedge clock) begin
      if (cmd.result_load) begin
         smooth_x_ff <= quo_x;
         smooth_y_ff <= quo_y;
      end
   end

   assign smooth_x          = smooth_x_ff;
   assign smooth_y          = smooth_y_ff;
   assign status.accum_last = (weight == fill_ff);
   assign status.div_last   = (bit_ff == BIT_W'(COORD_BITS - 1));

   // fill count never passes the window depth
   assert property (@(posedge clock) disable iff (reset)
      fill_ff <= CNT_W'(HISTORY_DEPTH))
      else $error("fill count beyond window depth");

   // accumulation only visits filled taps
   assert property (@(posedge clock) disable iff (reset)
      cmd.accum |-> (CNT_W'(idx_ff) < fill_ff))
      else $error("accumulation reads an unfilled tap");

endmodule

`default_nettype wire

/* hw/rtl/pws_ctrl.sv */
`default_nettype none

module pws_ctrl (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    req_valid,
   output logic                         req_stall,
   output logic                         rsp_valid,
   input  wire logic                    rsp_stall,
   output pws_pkg::pws_cmd_type         cmd,
   input  wire pws_pkg::pws_status_type status
);

   import pws_pkg::*;

   pws_state_type state_ff;
   pws_state_type state_in;
   logic          out_valid_ff;
   logic          out_valid_in;
   logic          out_free;

   assign out_free = !out_valid_ff || !rsp_stall;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               state_in = ST_ACCUM;
            end
         end
         ST_ACCUM: begin
            if (status.accum_last) begin
               state_in = ST_PREP;
            end
         end
         ST_PREP: begin
            state_in = ST_DIVIDE;
         end
         ST_DIVIDE: begin
            if (status.div_last) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // commands and request stall
   always_comb begin
      cmd       = '0;
      req_stall = 1'b1;
      unique case (state_ff)
         ST_IDLE: begin
            req_stall = 1'b0;
            cmd.load  = req_valid;
         end
         ST_ACCUM: begin
            cmd.accum = 1'b1;
         end
         ST_PREP: begin
            cmd.div_start = 1'b1;
         end
         ST_DIVIDE: begin
            cmd.div_step = 1'b1;
         end
         ST_DONE: begin
            cmd.result_load = out_free;
         end
         default: begin
            cmd = '0;
         end
      endcase
   end

   // result valid: set on load, cleared when taken
   always_comb begin
      if (cmd.result_load) begin
         out_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         out_valid_in = 1'b0;
      end else begin
         out_valid_in = out_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
      end
   end

   assign rsp_valid = out_valid_ff;

   // an accepted request starts accumulation
   assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> (state_ff == ST_ACCUM))
      else $error("accepted request did not start accumulation");

   // a waiting result is never overwritten
   assert property (@(posedge clock) disable iff (reset)
      cmd.result_load |-> (!out_valid_ff || !rsp_stall))
      else $error("result register overwritten while stalled");

endmodule

`default_nettype wire

/* hw/rtl/pointer_weighted_smoother_core.sv */
// an accepted point enters the window, then its n filled taps (n = 1..depth) are summed and divided
// req_stall stays high from accept until the result is loaded, so one request is handled at a time
// throughput is set by the tap-serial weighted sum and the bit-serial restoring divider
// a finished result waits in the output register while the next request is taken
// reset (synchronous, active high) empties the window and drops any pending result
`default_nettype none

module pointer_weighted_smoother_core #(
   parameter int HISTORY_DEPTH = pws_pkg::DEF_HISTORY_DEPTH,
   parameter int COORD_BITS    = pws_pkg::DEF_COORD_BITS
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output logic                       req_stall,
   input  wire logic [COORD_BITS-1:0] req_point_x,
   input  wire logic [COORD_BITS-1:0] req_point_y,
   output logic                       rsp_valid,
   input  wire logic                  rsp_stall,
   output logic      [COORD_BITS-1:0] rsp_smooth_x,
   output logic      [COORD_BITS-1:0] rsp_smooth_y
);

   import pws_pkg::*;

   pws_cmd_type    cmd;
   pws_status_type status;

   // sequencing of load, accumulate, divide and result hand-off
   pws_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .cmd       (cmd),
      .status    (status)
   );

   // window, weighted sums, dividers and output register
   pws_datapath #(
      .HISTORY_DEPTH (HISTORY_DEPTH),
      .COORD_BITS    (COORD_BITS)
   ) u_datapath (
      .clock    (clock),
      .reset    (reset),
      .cmd      (cmd),
      .status   (status),
      .point_x  (req_point_x),
      .point_y  (req_point_y),
      .smooth_x (rsp_smooth_x),
      .smooth_y (rsp_smooth_y)
   );

endmodule

`default_nettype wire
